// ===== rtl/core/nptt_pkg.sv =====
// shared constants, types and status codes of the port translation table
package nptt_pkg;

    localparam int TABLE_DEPTH       = 256;
    localparam int IDX_W             = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W             = $clog2(TABLE_DEPTH + 1);
    localparam int IP_W              = 32;
    localparam int PORT_W            = 16;
    localparam int STATUS_W          = 3;
    localparam int FIRST_PUBLIC_PORT = 80 + 1;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int HDR_W             = 2 * IP_W + 2 * PORT_W;
    localparam int ENTRY_W           = IP_W + PORT_W;
    localparam int IN_TDATA_W        = ((HDR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W       = ((HDR_W + STATUS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W         = OUT_TDATA_W - HDR_W - STATUS_W;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_IN_HIT   = 3'd0;
    localparam t_status ST_IN_MISS  = 3'd1;
    localparam t_status ST_OUT_HIT  = 3'd2;
    localparam t_status ST_OUT_NEW  = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // first member sits in the top bits, so src_ip lands in bits 31:0
    typedef struct packed {
        logic [PORT_W-1:0] dst_port;
        logic [IP_W-1:0]   dst_ip;
        logic [PORT_W-1:0] src_port;
        logic [IP_W-1:0]   src_ip;
    } t_hdr;

    typedef struct packed {
        logic              inbound;
        logic              port_ok;
        logic [PORT_W-1:0] in_idx;
        t_hdr              hdr;
    } t_work;

endpackage

// ===== rtl/core/nptt_front.sv =====
// input stage: takes header words and classifies them as inbound or outbound
module nptt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  nptt_pkg::t_hdr                i_hdr,
    input  logic [nptt_pkg::IP_W-1:0]     i_public_ip,
    output logic                          o_valid,
    input  logic                          i_ready,
    output nptt_pkg::t_work               o_work
);
    import nptt_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        n_work.hdr     = i_hdr;
        n_work.inbound = (i_hdr.dst_ip == i_public_ip);
        n_work.port_ok = (i_hdr.dst_port >= PORT_W'(FIRST_PUBLIC_PORT));
        n_work.in_idx  = i_hdr.dst_port - PORT_W'(FIRST_PUBLIC_PORT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== rtl/core/nptt_queue.sv =====
// short fifo of classified words between front and back
module nptt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  nptt_pkg::t_work  i_push_work,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output nptt_pkg::t_work  o_pop_work
);
    import nptt_pkg::*;

    t_work              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_work   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_work;
        end
    end

endmodule

// ===== rtl/core/nptt_back.sv =====
// table engine: entry memory, inbound lookup, outbound scan and insert, output register
module nptt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  nptt_pkg::t_work               i_work,
    input  logic [nptt_pkg::IP_W-1:0]     i_public_ip,
    output logic                          o_valid,
    input  logic                          i_ready,
    output nptt_pkg::t_hdr                o_hdr,
    output nptt_pkg::t_status             o_status
);
    import nptt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_IN_RD   = 5'b00010,
        S_IN_DATA = 5'b00100,
        S_SCAN    = 5'b01000,
        S_FIN     = 5'b10000
    } t_state;

    t_state              r_state,   n_state;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [CNT_W-1:0]    r_idx,     n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    t_work               r_work,    n_work;
    t_status             r_status,  n_status;
    logic                r_out_valid, n_out_valid;
    t_hdr                r_out_hdr,   n_out_hdr;
    t_status             r_out_status, n_out_status;

    logic [ENTRY_W-1:0]  r_table [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  r_rd_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                scan_hit;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_hdr    = r_out_hdr;
    assign o_status = r_out_status;

    assign scan_hit = r_cmp_vld && (r_rd_data == {r_work.hdr.src_ip, r_work.hdr.src_port});

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_work       = r_work;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_hdr    = r_out_hdr;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = r_idx[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_count[IDX_W-1:0];
        wr_data      = {r_work.hdr.src_ip, r_work.hdr.src_port};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_work    = i_work;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    if (i_work.inbound) begin
                        if (i_work.port_ok && (i_work.in_idx < PORT_W'(r_count))) begin
                            n_state = S_IN_RD;
                        end else begin
                            n_status = ST_IN_MISS;
                            n_state  = S_FIN;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_IN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_work.in_idx[IDX_W-1:0];
                n_state = S_IN_DATA;
            end
            S_IN_DATA: begin
                n_work.hdr.dst_ip   = r_rd_data[ENTRY_W-1:PORT_W];
                n_work.hdr.dst_port = r_rd_data[PORT_W-1:0];
                n_status            = ST_IN_HIT;
                n_state             = S_FIN;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_work.hdr.src_port = PORT_W'(FIRST_PUBLIC_PORT) + PORT_W'(r_cmp_idx);
                    n_work.hdr.src_ip   = i_public_ip;
                    n_status            = ST_OUT_HIT;
                    n_cmp_vld           = 1'b0;
                    n_state             = S_FIN;
                end else if (!r_cmp_vld && (r_idx >= r_count)) begin
                    if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en               = 1'b1;
                        n_count             = r_count + 1'b1;
                        n_work.hdr.src_port = PORT_W'(FIRST_PUBLIC_PORT) + PORT_W'(r_count);
                        n_work.hdr.src_ip   = i_public_ip;
                        n_status            = ST_OUT_NEW;
                    end
                    n_state = S_FIN;
                end else if (r_idx < r_count) begin
                    // read one entry per cycle, compare it the cycle after
                    rd_en     = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_hdr    = r_work.hdr;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx    <= n_cmp_idx;
        r_work       <= n_work;
        r_status     <= n_status;
        r_out_hdr    <= n_out_hdr;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

endmodule

// ===== rtl/core/nat_port_translation_table.sv =====
// path: input register, queue, table engine, output register; an inbound hit reads its
// entry in IN_RD and IN_DATA, an inbound miss goes straight to FIN, and an outbound word
// scans the entries up to its match, or all of them before an insert, then goes to FIN
// throughput: one word at a time in the engine; its outbound scan reads one table entry
// per cycle; a two-word queue and an input register let new words arrive while it works
// reset: synchronous, active low; clears the entry count, queue and public address
module nat_port_translation_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [nptt_pkg::IP_W-1:0]          i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // src_ip, src_port, dst_ip, dst_port
    input  logic [nptt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_src_ip, out_src_port, out_dst_ip, out_dst_port, status, zero pad
    output logic [nptt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import nptt_pkg::*;

    logic [IP_W-1:0] r_public_ip;
    t_hdr            in_hdr;
    logic            fr_valid;
    logic            fr_ready;
    t_work           fr_work;
    logic            q_valid;
    logic            q_ready;
    t_work           q_work;
    t_hdr            out_hdr;
    t_status         out_status;

    assign in_hdr       = s_axis_tdata[HDR_W-1:0];
    assign m_axis_tdata = {OUT_PAD_W'(0), out_status, out_hdr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_public_ip <= '0;
        end else if (i_cfg_wr_en) begin
            r_public_ip <= i_cfg_wr_data;
        end
    end

    nptt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_hdr       (in_hdr),
        .i_public_ip (r_public_ip),
        .o_valid     (fr_valid),
        .i_ready     (fr_ready),
        .o_work      (fr_work)
    );

    nptt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_work  (fr_work),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_work   (q_work)
    );

    nptt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_work      (q_work),
        .i_public_ip (r_public_ip),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_hdr       (out_hdr),
        .o_status    (out_status)
    );

endmodule

// ===== rtl/core/nptt_checker.sv =====
// port-level checks on the translation table and their bind
module nptt_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [nptt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import nptt_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [PORT_W-1:0]   sport;

    assign st    = m_axis_tdata[HDR_W +: STATUS_W];
    assign sport = m_axis_tdata[IP_W +: PORT_W];

    // no word comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (st == ST_IN_HIT || st == ST_IN_MISS || st == ST_OUT_HIT ||
                           st == ST_OUT_NEW || st == ST_FULL))
        else $error("unknown status code");

    // translated outbound words always carry an allocated public port
    a_out_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (st == ST_OUT_HIT || st == ST_OUT_NEW)
            |-> sport >= PORT_W'(FIRST_PUBLIC_PORT))
        else $error("outbound public port below first public port");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:HDR_W+STATUS_W] == '0)
        else $error("pad bits of output word not zero");

endmodule

bind nat_port_translation_table nptt_checker u_nptt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/nat_port_translation_table_tb.sv =====
// self-checking testbench of the port translation table with a header translation predictor
module nat_port_translation_table_tb;
    import nptt_pkg::*;

    localparam int PER_PHASE   = 308;
    localparam int TAIL_CYCLES = 16;
    localparam int LIMIT       = 1_500_000;

    typedef struct packed {
        t_status status;
        t_hdr    hdr;
    } t_translated;

    class translation_checker;
        logic [IP_W-1:0]   public_addr;
        logic [IP_W-1:0]   priv_ip [TABLE_DEPTH];
        logic [PORT_W-1:0] priv_port [TABLE_DEPTH];
        int                entry_count;
        t_translated       expected_hdrs[$];
        int                errors;

        function new();
            public_addr = '0;
            entry_count = 0;
            errors      = 0;
        endfunction

        function void note_header(t_hdr h);
            t_translated r;
            int idx;
            r.hdr    = h;
            r.status = ST_IN_MISS;
            if (h.dst_ip == public_addr) begin
                idx = int'(h.dst_port) - FIRST_PUBLIC_PORT;
                if (idx >= 0 && idx < entry_count) begin
                    r.hdr.dst_ip   = priv_ip[idx];
                    r.hdr.dst_port = priv_port[idx];
                    r.status       = ST_IN_HIT;
                end
            end else begin
                idx = -1;
                for (int i = 0; i < entry_count; i++)
                    if (idx < 0 && priv_ip[i] == h.src_ip && priv_port[i] == h.src_port)
                        idx = i;
                if (idx >= 0) begin
                    r.hdr.src_port = PORT_W'(FIRST_PUBLIC_PORT + idx);
                    r.hdr.src_ip   = public_addr;
                    r.status       = ST_OUT_HIT;
                end else if (entry_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    priv_ip[entry_count]   = h.src_ip;
                    priv_port[entry_count] = h.src_port;
                    r.hdr.src_port = PORT_W'(FIRST_PUBLIC_PORT + entry_count);
                    r.hdr.src_ip   = public_addr;
                    r.status       = ST_OUT_NEW;
                    entry_count++;
                end
            end
            expected_hdrs.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_translated exp_r;
            t_hdr        got;
            t_status     st;
            got = word[HDR_W-1:0];
            st  = word[HDR_W +: STATUS_W];
            if (expected_hdrs.size() == 0) begin
                $error("word with no expected result: %h", word);
                errors++;
                return;
            end
            exp_r = expected_hdrs.pop_front();
            compare("out_src_ip", exp_r.hdr.src_ip, got.src_ip);
            compare("out_src_port", 32'(exp_r.hdr.src_port), 32'(got.src_port));
            compare("out_dst_ip", exp_r.hdr.dst_ip, got.dst_ip);
            compare("out_dst_port", 32'(exp_r.hdr.dst_port), 32'(got.dst_port));
            compare("status", 32'(exp_r.status), 32'(st));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [IP_W-1:0]        i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // src_ip, src_port, dst_ip, dst_port
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // out_src_ip, out_src_port, out_dst_ip, out_dst_port, status, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    translation_checker sb;
    int idle_pct;
    int cycle_count = 0;

    nat_port_translation_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // receiver stalls
    initial begin
        int n;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 5) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [IP_W-1:0] addr_other_than(logic [IP_W-1:0] a);
        logic [IP_W-1:0] v;
        v = $urandom;
        if (v == a)
            v[0] = ~v[0];
        return v;
    endfunction

    function automatic logic [PORT_W-1:0] rand_port();
        return PORT_W'($urandom_range(0, 65535));
    endfunction

    task automatic pause(int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_hdr(logic [IP_W-1:0] sip, logic [PORT_W-1:0] sport,
                            logic [IP_W-1:0] dip, logic [PORT_W-1:0] dport);
        t_hdr h;
        h.src_ip   = sip;
        h.src_port = sport;
        h.dst_ip   = dip;
        h.dst_port = dport;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            pause($urandom_range(1, 16));
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_header(h);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_hdrs.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_public(logic [IP_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.public_addr = v;
    endtask

    task automatic send_random();
        logic [IP_W-1:0]   sip;
        logic [PORT_W-1:0] sport;
        logic [IP_W-1:0]   dip;
        logic [PORT_W-1:0] dport;
        int pick;
        int k;
        sip   = $urandom;
        sport = rand_port();
        dip   = addr_other_than(sb.public_addr);
        dport = rand_port();
        pick  = $urandom_range(0, 99);
        if (pick < 30) begin
            // fresh outbound pair
        end else if (pick < 55 && sb.entry_count > 0) begin
            k     = $urandom_range(0, sb.entry_count - 1);
            sip   = sb.priv_ip[k];
            sport = sb.priv_port[k];
        end else if (pick < 80 && sb.entry_count > 0) begin
            dip   = sb.public_addr;
            dport = PORT_W'(FIRST_PUBLIC_PORT + $urandom_range(0, sb.entry_count - 1));
        end else if (pick < 90) begin
            dip = sb.public_addr;
            case ($urandom_range(0, 3))
                0: dport = rand_port();
                1: dport = PORT_W'($urandom_range(0, FIRST_PUBLIC_PORT - 1));
                2: dport = PORT_W'(FIRST_PUBLIC_PORT + sb.entry_count);
                default: dport = '1;
            endcase
        end else begin
            dip = $urandom;
        end
        send_hdr(sip, sport, dip, dport);
    endtask

    initial begin
        logic [IP_W-1:0] phase_addr [4];
        int phase_idle [4];
        sb = new();
        idle_pct      = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // public address still at its reset value of zero
        idle_pct = 20;
        send_hdr($urandom, rand_port(), 32'h0, 16'd81);
        send_hdr($urandom, rand_port(), 32'h0, 16'd0);
        send_hdr(32'h0, 16'h0, 32'h1, 16'h0);
        send_hdr(32'hffff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff);
        send_hdr(32'h0, 16'h0, 32'h2, 16'hffff);
        send_hdr(32'hffff_ffff, 16'hffff, 32'h3, 16'h1234);
        send_hdr(32'h0, 16'hffff, 32'h4, 16'h0);
        send_hdr(32'hffff_ffff, 16'h0, 32'h5, 16'h0);
        send_hdr($urandom, rand_port(), 32'h0, 16'd81);
        send_hdr($urandom, rand_port(), 32'h0, 16'd82);
        send_hdr($urandom, rand_port(), 32'h0, 16'd84);
        send_hdr($urandom, rand_port(), 32'h0, 16'd85);
        send_hdr($urandom, rand_port(), 32'h0, 16'd80);
        send_hdr($urandom, rand_port(), 32'h0, 16'hffff);
        // entries stay valid across a change of the public address
        write_public(32'hffff_ffff);
        send_hdr($urandom, rand_port(), 32'hffff_ffff, 16'd81);
        send_hdr(32'h0, 16'h0, 32'h0, 16'd81);
        send_hdr($urandom, rand_port(), 32'h0, 16'h0);
        send_hdr($urandom, rand_port(), 32'hffff_ffff, 16'h0);

        phase_addr[0] = $urandom;
        phase_addr[1] = 32'h0;
        phase_addr[2] = $urandom;
        phase_addr[3] = 32'hffff_ffff;
        phase_idle[0] = 40;
        phase_idle[1] = 10;
        phase_idle[2] = 25;
        phase_idle[3] = 0;
        for (int p = 0; p < 4; p++) begin
            write_public(phase_addr[p]);
            idle_pct = phase_idle[p];
            repeat (PER_PHASE) send_random();
        end

        drain();
        if (sb.errors == 0 && sb.expected_hdrs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
